>>> rtl/mtsk_pkg.sv
`default_nettype none
package mtsk_pkg;

  // operation codes of the input beat
  typedef enum logic [2:0] {
    CMD_ADD_TICKS = 3'd0,
    CMD_SET_LOCAL = 3'd1,
    CMD_SET_MESH  = 3'd2,
    CMD_SET_NET   = 3'd3,
    CMD_CORRECT   = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_ASSET_DEVICE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_NEG_OFFSET  = 2'd2;

  localparam logic [15:0] TPS_RESET = 16'd32768;

  localparam int SECONDS_PER_MINUTE = 60;
  // zone minutes times sixty fits in this many signed bits
  localparam int OFF_W = 22;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;
    logic div_step;
    logic fold;
    logic sum;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_read;
    logic tps_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/mtsk_in_if.sv
`default_nettype none
interface mtsk_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  cmd;
  logic        [31:0] base_seconds;
  logic        [31:0] since_base_seconds;
  logic        [31:0] tick_count;
  logic signed [15:0] zone_minutes;
  logic        [31:0] generation_in;

  modport source (
    output valid, cmd, base_seconds, since_base_seconds, tick_count, zone_minutes,
           generation_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, base_seconds, since_base_seconds, tick_count, zone_minutes,
           generation_in,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/mtsk_out_if.sv
`default_nettype none
interface mtsk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] local_time;
  logic [31:0] leftover_ticks;
  logic        is_synced;
  logic        is_corrected;
  logic        set_accepted;
  logic [31:0] generation_out;

  modport source (
    output valid, local_time, leftover_ticks, is_synced, is_corrected, set_accepted,
           generation_out,
    input  ready
  );
  modport sink (
    input  valid, local_time, leftover_ticks, is_synced, is_corrected, set_accepted,
           generation_out,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/mesh_time_sync_keeper.sv
// add, set and correction commands go from the accepted beat straight to the finish step
// a read runs 32 steps of the serial tick divider, then fold, sum and finish
// (only sum and finish when ticks_per_second is zero); one item is worked on at a time
// the result register lets a new beat in while the previous result waits
// rst_n is synchronous and active low: clock state clears, control and configuration registers take their reset values
`default_nettype none
module mesh_time_sync_keeper (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mtsk_in_if.sink                              in_bus,
  mtsk_out_if.source                           out_bus,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mtsk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mtsk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mtsk_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mtsk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mtsk_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_cmd                (in_bus.cmd),
    .in_base_seconds       (in_bus.base_seconds),
    .in_since_base_seconds (in_bus.since_base_seconds),
    .in_tick_count         (in_bus.tick_count),
    .in_zone_minutes       (in_bus.zone_minutes),
    .in_generation_in      (in_bus.generation_in),
    .cmd                   (dp_cmd),
    .sts                   (dp_sts),
    .out_local_time        (out_bus.local_time),
    .out_leftover_ticks    (out_bus.leftover_ticks),
    .out_is_synced         (out_bus.is_synced),
    .out_is_corrected      (out_bus.is_corrected),
    .out_set_accepted      (out_bus.set_accepted),
    .out_generation_out    (out_bus.generation_out)
  );

endmodule
`default_nettype wire

>>> rtl/mtsk_ctrl.sv
`default_nettype none
module mtsk_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire mtsk_pkg::dp_sts_t sts,
  output mtsk_pkg::dp_cmd_t      cmd
);
  import mtsk_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_FOLD = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 div_last;

  assign out_free  = !out_valid_r || out_ready;
  assign div_last  = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          if (!sts.in_read) state_nxt = ST_FIN;
          else if (sts.tps_zero) state_nxt = ST_SUM;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register can take the beat
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mtsk_dp.sv
`default_nettype none
module mtsk_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mtsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mtsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic        [2:0]                   in_cmd,
  input  wire logic        [31:0]                  in_base_seconds,
  input  wire logic        [31:0]                  in_since_base_seconds,
  input  wire logic        [31:0]                  in_tick_count,
  input  wire logic signed [15:0]                  in_zone_minutes,
  input  wire logic        [31:0]                  in_generation_in,
  input  wire mtsk_pkg::dp_cmd_t                   cmd,
  output mtsk_pkg::dp_sts_t                        sts,
  output logic             [31:0]                  out_local_time,
  output logic             [31:0]                  out_leftover_ticks,
  output logic                                     out_is_synced,
  output logic                                     out_is_corrected,
  output logic                                     out_set_accepted,
  output logic             [31:0]                  out_generation_out
);
  import mtsk_pkg::*;

  // configuration
  logic [15:0] tps_r;
  logic        asset_r;
  logic        clamp_r;

  // latched input beat
  logic        [2:0]  cmd_r;
  logic        [31:0] base_in_r;
  logic        [31:0] since_in_r;
  logic        [31:0] ticks_in_r;
  logic signed [15:0] zone_in_r;
  logic        [31:0] gen_in_r;

  // clock state
  logic        [31:0] sync_base_r, sync_base_nxt;
  logic        [31:0] elapsed_r, elapsed_nxt;
  logic        [31:0] pending_r, pending_nxt;
  logic signed [15:0] zone_r, zone_nxt;
  logic        [31:0] gen_r, gen_nxt;
  logic               await_r, await_nxt;
  logic               seen_r, seen_nxt;

  // restoring divider
  logic [15:0] rem_r;
  logic [31:0] quo_r;
  logic [16:0] trial;
  logic        trial_ge;

  // read path
  logic        [31:0]      plain_r;
  logic signed [OFF_W-1:0] off60_r;
  logic        [OFF_W-1:0] mag;
  logic        [31:0]      mag32;
  logic        [31:0]      lt_c;
  logic                    acc_c;
  logic                    synced_c;
  logic                    corrected_c;

  assign sts.in_read  = (in_cmd == CMD_READ);
  assign sts.tps_zero = (tps_r == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= TPS_RESET;
      asset_r <= 1'b0;
      clamp_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r   <= cfg_wdata[15:0];
        CFG_IS_ASSET_DEVICE:  asset_r <= cfg_wdata[0];
        CFG_CLAMP_NEG_OFFSET: clamp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_cmd;
      base_in_r  <= in_base_seconds;
      since_in_r <= in_since_base_seconds;
      ticks_in_r <= in_tick_count;
      zone_in_r  <= in_zone_minutes;
      gen_in_r   <= in_generation_in;
    end
  end

  assign trial    = {rem_r, quo_r[31]};
  assign trial_ge = (trial >= {1'b0, tps_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      quo_r <= pending_r;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? 16'(trial - {1'b0, tps_r}) : trial[15:0];
      quo_r <= {quo_r[30:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      plain_r <= sync_base_r + elapsed_r;
      off60_r <= OFF_W'(zone_r) * OFF_W'(SECONDS_PER_MINUTE);
    end
  end

  assign mag   = OFF_W'(-off60_r);
  assign mag32 = {{(32-OFF_W){1'b0}}, mag};

  always_comb begin
    if (off60_r < 0) begin
      if (clamp_r && (plain_r < mag32)) lt_c = plain_r;
      else lt_c = plain_r - mag32;
    end else begin
      lt_c = plain_r + {{(32-OFF_W){1'b0}}, off60_r[OFF_W-1:0]};
    end
  end

  always_comb begin
    sync_base_nxt = sync_base_r;
    elapsed_nxt   = elapsed_r;
    pending_nxt   = pending_r;
    zone_nxt      = zone_r;
    gen_nxt       = gen_r;
    await_nxt     = await_r;
    seen_nxt      = seen_r;
    acc_c         = 1'b0;
    if (cmd.fold) begin
      elapsed_nxt = elapsed_r + quo_r;
      pending_nxt = {16'd0, rem_r};
    end
    if (cmd.commit) begin
      unique case (cmd_t'(cmd_r))
        CMD_ADD_TICKS: pending_nxt = pending_r + ticks_in_r;
        CMD_SET_LOCAL: acc_c = 1'b1;
        CMD_SET_MESH:  acc_c = (gen_in_r > gen_r);
        CMD_SET_NET:   acc_c = (gen_r == 32'd0) || asset_r;
        CMD_CORRECT: begin
          if (await_r) begin
            pending_nxt = pending_r + ticks_in_r;
            await_nxt   = 1'b0;
            seen_nxt    = 1'b1;
          end
        end
        default: ;
      endcase
      if (acc_c) begin
        sync_base_nxt = base_in_r;
        elapsed_nxt   = since_in_r;
        pending_nxt   = ticks_in_r;
        zone_nxt      = zone_in_r;
        unique case (cmd_t'(cmd_r))
          CMD_SET_MESH: begin
            gen_nxt   = gen_in_r;
            await_nxt = 1'b1;
            seen_nxt  = 1'b0;
          end
          CMD_SET_LOCAL: begin
            gen_nxt   = gen_r + 32'd1;
            await_nxt = 1'b0;
            seen_nxt  = 1'b1;
          end
          default: begin
            gen_nxt   = gen_r + 32'd1;
            await_nxt = 1'b0;
            seen_nxt  = 1'b0;
          end
        endcase
      end
    end
  end

  assign synced_c    = (sync_base_nxt != 32'd0);
  assign corrected_c = synced_c && (seen_nxt || !await_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_base_r <= '0;
      elapsed_r   <= '0;
      pending_r   <= '0;
      zone_r      <= '0;
      gen_r       <= '0;
      await_r     <= 1'b0;
      seen_r      <= 1'b0;
    end else begin
      sync_base_r <= sync_base_nxt;
      elapsed_r   <= elapsed_nxt;
      pending_r   <= pending_nxt;
      zone_r      <= zone_nxt;
      gen_r       <= gen_nxt;
      await_r     <= await_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // result register, loaded with the state after the command
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_local_time     <= (cmd_r == CMD_READ) ? lt_c : 32'd0;
      out_leftover_ticks <= (cmd_r == CMD_READ) ? pending_r : 32'd0;
      out_is_synced      <= synced_c;
      out_is_corrected   <= corrected_c;
      out_set_accepted   <= acc_c;
      out_generation_out <= gen_nxt;
    end
  end

endmodule
`default_nettype wire
